// ===== design/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ball-and-stick signal predictor package
// Widths, register indexes, reset values and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BASE_INTENSITY = 3'd0;
  localparam logic [2:0] REG_DIFFUSIVITY    = 3'd1;
  localparam logic [2:0] REG_STICK_FRACTION = 3'd2;
  localparam logic [2:0] REG_STICK_DIR_X    = 3'd3;
  localparam logic [2:0] REG_STICK_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_STICK_DIR_Z    = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // reset values
  localparam logic [15:0] RST_BASE_INTENSITY = 16'd1000;
  localparam logic [19:0] RST_DIFFUSIVITY    = 20'd50331;
  localparam logic [16:0] RST_STICK_FRACTION = 17'd32768;
  localparam logic [15:0] RST_STICK_DIR_X    = 16'd0;
  localparam logic [15:0] RST_STICK_DIR_Y    = 16'd0;
  localparam logic [15:0] RST_STICK_DIR_Z    = 16'd32767;

  // fixed point constants
  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [40:0] EXP_LIMIT = 41'd12 << 24;
  localparam int          XW        = 41;   // exponent argument width, Q.24
  localparam int          EW        = 31;   // exponential result width, Q.30
  localparam int          EXP_STAGES = 10;

  // floor(x / 3) for 24-bit x: multiply by ceil(2^26 / 3), shift by 26
  function automatic logic [22:0] div3(input logic [23:0] x);
    logic [48:0] p;
    begin
      p = {25'd0, x} * 49'd22369622;
      div3 = p[48:26];
    end
  endfunction

endpackage

// ===== design/bsp_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// One gradient direction per transaction: b-value, direction, last mark.
// ----------------------------------------------------------------------------
interface bsp_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] b_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic               last_direction;

  modport source (output valid, b_value, grad_x, grad_y, grad_z, last_direction,
                  input ready);
  modport sink   (input valid, b_value, grad_x, grad_y, grad_z, last_direction,
                  output ready);
endinterface

// ===== design/bsp_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// One predicted intensity per transaction, with the last mark.
// ----------------------------------------------------------------------------
interface bsp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] predicted_signal;
  logic        last_out;

  modport source (output valid, predicted_signal, last_out, input ready);
  modport sink   (input valid, predicted_signal, last_out, output ready);
endinterface

// ===== design/bsp_exp.sv =====
// ----------------------------------------------------------------------------
// Pipelined exp(-x)
// x in Q.24, result in Q.30. Fourth-order series on x/64, then six
// squarings, one stage each. Underflows to zero at x >= 12.
// ----------------------------------------------------------------------------
module bsp_exp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [bsp_pkg::EXP_STAGES-1:0]       en,
  input  logic [bsp_pkg::XW-1:0]               x,
  output logic [bsp_pkg::EW-1:0]               y
);

  // series stage registers
  logic [27:0] t1, t2s, t3s;
  logic [26:0] p2_1, p2_2, p2_3;
  logic [24:0] p3_2;
  logic [22:0] q6_3;
  logic [22:0] p4_3;
  logic [bsp_pkg::EW-1:0] e4;
  logic [bsp_pkg::EXP_STAGES-1:0] zf;
  logic [bsp_pkg::EW-1:0] sq [0:5];

  logic [56:0] m1;
  logic [55:0] m2;
  logic [53:0] m3;
  logic [32:0] esum;
  logic [61:0] m_sq [0:5];

  // power terms with rounding
  assign m1 = 57'(x[27:0]) * 57'(x[27:0]) + 57'(1 << 29);
  assign m2 = 56'(p2_1) * 56'(t1) + 56'(1 << 29);
  assign m3 = 54'(p3_2) * 54'(t2s) + 54'(1 << 29);

  // series sum, stays within 0..2^30
  assign esum = 33'(bsp_pkg::ONE_Q30) - 33'(t3s) + 33'(p2_3[26:1]) - 33'(q6_3)
              + 33'(bsp_pkg::div3({4'd0, p4_3[22:3]}));

  // squaring products
  always_comb begin
    m_sq[0] = 62'(e4) * 62'(e4) + 62'(1 << 29);
    for (int k = 1; k < 6; k++) begin
      m_sq[k] = 62'(sq[k-1]) * 62'(sq[k-1]) + 62'(1 << 29);
    end
  end

  // underflow flag travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      zf <= '0;
    end else begin
      if (en[0]) zf[0] <= (x >= bsp_pkg::EXP_LIMIT);
      for (int k = 1; k < bsp_pkg::EXP_STAGES; k++) begin
        if (en[k]) zf[k] <= zf[k-1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1   <= x[27:0];
      p2_1 <= m1[56:30];
    end
    if (en[1]) begin
      t2s  <= t1;
      p2_2 <= p2_1;
      p3_2 <= m2[54:30];
    end
    if (en[2]) begin
      t3s  <= t2s;
      p2_3 <= p2_2;
      q6_3 <= bsp_pkg::div3(p3_2[24:1]);
      p4_3 <= m3[52:30];
    end
    if (en[3]) begin
      e4 <= esum[30:0];
    end
    for (int k = 0; k < 6; k++) begin
      if (en[4+k]) sq[k] <= m_sq[k][60:30];
    end
  end

  assign y = zf[bsp_pkg::EXP_STAGES-1] ? '0 : sq[5];

  // the series never exceeds one; stages not yet loaded are skipped
  a_series_bound: assert property (@(posedge clk) disable iff (rst)
    (en[4] && !$isunknown(e4)) |-> (e4 <= bsp_pkg::ONE_Q30))
    else $error("exp series above one");

endmodule

// ===== design/ball_stick_signal_predict_unit.sv =====
// ----------------------------------------------------------------------------
// Ball-and-stick signal predictor
// S = b0 * ((1-f)*exp(-b*d) + f*exp(-b*d*(v.g)^2)), fixed point, saturated.
// ----------------------------------------------------------------------------
// A 16-stage pipeline that takes one gradient direction per clock unless a
// stalled output has filled every stage. Stages 1-4 form the dot product,
// its square and both exponents; stages 5-14 are two parallel exponential
// units (series then six squarings, one squaring per stage); stage 15 mixes
// ball and stick, stage 16 scales, rounds and saturates into the output
// register. Each stage holds its item until the next one frees, so empty
// stages keep filling while the output waits.
// Registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while no transaction is in flight.
module ball_stick_signal_predict_unit (
  input  logic                            clk,
  input  logic                            rst,
  bsp_in_if.sink                          din,
  bsp_out_if.source                       dout,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NS = 16;

  // configuration registers
  logic        [15:0] base_intensity;
  logic        [19:0] diffusivity;
  logic        [16:0] stick_fraction;
  logic signed [15:0] stick_dir_x, stick_dir_y, stick_dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_intensity <= bsp_pkg::RST_BASE_INTENSITY;
      diffusivity    <= bsp_pkg::RST_DIFFUSIVITY;
      stick_fraction <= bsp_pkg::RST_STICK_FRACTION;
      stick_dir_x    <= bsp_pkg::RST_STICK_DIR_X;
      stick_dir_y    <= bsp_pkg::RST_STICK_DIR_Y;
      stick_dir_z    <= bsp_pkg::RST_STICK_DIR_Z;
    end else if (cfg_we) begin
      case (cfg_index)
        bsp_pkg::REG_BASE_INTENSITY: base_intensity <= cfg_data[15:0];
        bsp_pkg::REG_DIFFUSIVITY:    diffusivity    <= cfg_data;
        bsp_pkg::REG_STICK_FRACTION: stick_fraction <= cfg_data[16:0];
        bsp_pkg::REG_STICK_DIR_X:    stick_dir_x    <= cfg_data[15:0];
        bsp_pkg::REG_STICK_DIR_Y:    stick_dir_y    <= cfg_data[15:0];
        bsp_pkg::REG_STICK_DIR_Z:    stick_dir_z    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage enables
  logic [NS:1] v, en;

  always_comb begin
    en[NS] = !v[NS] || dout.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign din.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= din.valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // last mark travels alongside
  logic [NS:1] last_p;

  always_ff @(posedge clk) begin
    if (en[1]) last_p[1] <= din.last_direction;
    for (int k = 2; k <= NS; k++) begin
      if (en[k]) last_p[k] <= last_p[k-1];
    end
  end

  // stages 1-4: products, |dot|, dot^2, exponents
  logic signed [31:0] px, py, pz;
  logic        [35:0] xb1, xb2, xb3, xb4;
  logic        [31:0] a2;
  logic        [19:0] sq3;
  logic        [40:0] xs4;
  logic signed [33:0] dot;
  logic        [63:0] asq;
  logic        [56:0] xsp;

  assign dot = 34'(px) + 34'(py) + 34'(pz);
  assign asq = 64'(a2) * 64'(a2) + (64'(1) << 43);
  assign xsp = 57'(xb3) * 57'(sq3) + 57'(1 << 15);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px  <= stick_dir_x * din.grad_x;
      py  <= stick_dir_y * din.grad_y;
      pz  <= stick_dir_z * din.grad_z;
      xb1 <= din.b_value * diffusivity;
    end
    if (en[2]) begin
      a2  <= dot[33] ? 32'(-dot) : dot[31:0];
      xb2 <= xb1;
    end
    if (en[3]) begin
      sq3 <= asq[63:44];
      xb3 <= xb2;
    end
    if (en[4]) begin
      xs4 <= xsp[56:16];
      xb4 <= xb3;
    end
  end

  // stages 5-14: ball and stick exponentials
  logic [bsp_pkg::EW-1:0] eb, es;

  bsp_exp u_exp_ball (
    .clk (clk),
    .rst (rst),
    .en  (en[14:5]),
    .x   ({5'd0, xb4}),
    .y   (eb)
  );

  bsp_exp u_exp_stick (
    .clk (clk),
    .rst (rst),
    .en  (en[14:5]),
    .x   (xs4),
    .y   (es)
  );

  // stage 15: volume fraction mix, Q.46
  logic [16:0] f_c, f_ball;
  logic [46:0] mix;

  assign f_c    = (stick_fraction > bsp_pkg::FRAC_ONE) ? bsp_pkg::FRAC_ONE : stick_fraction;
  assign f_ball = bsp_pkg::FRAC_ONE - f_c;

  always_ff @(posedge clk) begin
    if (en[15]) mix <= 47'(f_ball) * 47'(eb) + 47'(f_c) * 47'(es);
  end

  // stage 16: scale, round, saturate
  logic [63:0] sc;
  logic [15:0] pred;

  assign sc = 64'(base_intensity) * 64'(mix) + (64'(1) << 45);

  always_ff @(posedge clk) begin
    if (en[16]) pred <= (sc[63:62] != 2'd0) ? 16'hFFFF : sc[61:46];
  end

  assign dout.valid            = v[NS];
  assign dout.predicted_signal = pred;
  assign dout.last_out         = last_p[NS];

  // a blocked input means every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (&v))
    else $error("input blocked with an empty stage");

  // mix never exceeds b0 weight of one
  a_mix_bound: assert property (@(posedge clk) disable iff (rst)
    v[15] |-> (mix <= (47'(1) << 46)))
    else $error("mix above one");

  // a held result is not dropped from the output stage
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NS] && !dout.ready) |=> v[NS])
    else $error("stalled result lost");

endmodule
